@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg: shared types and codes of the complex arithmetic unit
// Operation and status codes and the command and result transaction formats.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ACT_W      = 3;
	localparam int ST_W       = 2;

	localparam logic [ACT_W-1:0] ACT_MUL  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DIV  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CONJ = 3'd2;
	localparam logic [ACT_W-1:0] ACT_INV  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ABS2 = 3'd4;
	localparam logic [ACT_W-1:0] ACT_ABS  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_L1   = 3'd6;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]             action;
		logic signed [DATA_WIDTH-1:0] a_re;
		logic signed [DATA_WIDTH-1:0] a_im;
		logic signed [DATA_WIDTH-1:0] b_re;
		logic signed [DATA_WIDTH-1:0] b_im;
	} cau_cmd_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res_re;
		logic signed [DATA_WIDTH-1:0] res_im;
		logic [ST_W-1:0]              status;
	} cau_res_t;

endpackage

@@ hdl/complex_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit_top: pipelined fixed-point complex arithmetic unit
// Multiply, divide, conjugate, reciprocal, squared magnitude, magnitude and
// L1 norm of Q-format complex operands, with saturation and status.
// ----------------------------------------------------------------------------
// The unit takes one command transaction in every clock cycle and never
// raises busy. Every operation passes through the same pipeline and has the
// same latency, which is set by the restoring divider and the square root,
// which resolve one quotient or root bit per pipeline stage over
// DATA_WIDTH + 2 stages, behind four stages of operand capture, products,
// sums and divider setup, and one output register. Results come out in
// command order, each on the result port for the single cycle marked by done.
// ----------------------------------------------------------------------------
module complex_arith_unit_top import cau_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cau_cmd_t cmd,
	output logic     done,
	output cau_res_t result
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int DW  = 2 * W + 1;
	localparam int QN  = W + 2;
	localparam int RW  = QN + 2;
	localparam int NW  = 2 * W + 2 * F + 2;
	localparam int MW  = NW + 2;
	localparam int LAT = QN + 5;

	localparam logic [MW-1:0] MAXP = (MW'(1) << (W - 1)) - MW'(1);

	typedef struct packed {
		logic                sat;
		logic signed [W-1:0] val;
	} pk_t;

	typedef struct packed {
		logic                vld;
		logic [ACT_W-1:0]    act;
		logic signed [W-1:0] e_re;
		logic signed [W-1:0] e_im;
		logic [ST_W-1:0]     e_st;
		logic                neg_re;
		logic                neg_im;
		logic                ov_re;
		logic                ov_im;
		logic                dz;
		logic [DW-1:0]       den;
		logic [DW-1:0]       r_re;
		logic [DW-1:0]       r_im;
		logic [QN-1:0]       low_re;
		logic [QN-1:0]       low_im;
		logic [QN-1:0]       q_re;
		logic [QN-1:0]       q_im;
		logic [2*QN-1:0]     sx;
		logic [RW-1:0]       rem;
		logic [QN-1:0]       root;
	} it_t;

	// Saturating conversion of sign and magnitude to a W-bit two's complement.
	function automatic pk_t sat_pack(input logic neg, input logic [MW-1:0] mag);
		pk_t p;
		p.sat = 1'b0;
		if (!neg) begin
			if (mag > MAXP) begin
				p.sat = 1'b1;
				p.val = MAXP[W-1:0];
			end else begin
				p.val = mag[W-1:0];
			end
		end else begin
			if (mag > MAXP + MW'(1)) begin
				p.sat = 1'b1;
				p.val = ~MAXP[W-1:0];
			end else begin
				p.val = -mag[W-1:0];
			end
		end
		return p;
	endfunction

	function automatic logic [MW-1:0] rnd_shift(input logic [MW-1:0] mag);
		return (mag + (MW'(1) << (F - 1))) >> F;
	endfunction

	// Stage 1: operand capture.
	logic     v_s1;
	cau_cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// Stage 2: products. The two squares are of b for divide, else of a.
	logic                 v_s2;
	logic [ACT_W-1:0]     act_s2;
	logic signed [W-1:0]  ar_s2, ai_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [W-1:0]  sq_x, sq_y;

	assign sq_x = (cmd_s1.action == ACT_DIV) ? cmd_s1.b_re : cmd_s1.a_re;
	assign sq_y = (cmd_s1.action == ACT_DIV) ? cmd_s1.b_im : cmd_s1.a_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s2 <= cmd_s1.action;
		ar_s2  <= cmd_s1.a_re;
		ai_s2  <= cmd_s1.a_im;
		p0_s2  <= cmd_s1.a_re * cmd_s1.b_re;
		p1_s2  <= cmd_s1.a_im * cmd_s1.b_im;
		p2_s2  <= cmd_s1.a_re * cmd_s1.b_im;
		p3_s2  <= cmd_s1.a_im * cmd_s1.b_re;
		p4_s2  <= sq_x * sq_x;
		p5_s2  <= sq_y * sq_y;
	end

	// Stage 3: exact sums.
	logic                 v_s3;
	logic [ACT_W-1:0]     act_s3;
	logic signed [W-1:0]  ar_s3, ai_s3;
	logic signed [DW-1:0] xr_s3, xi_s3;
	logic [DW-1:0]        den_s3;
	logic signed [DW-1:0] e0, e1, e2, e3;

	assign e0 = DW'(p0_s2);
	assign e1 = DW'(p1_s2);
	assign e2 = DW'(p2_s2);
	assign e3 = DW'(p3_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		act_s3 <= act_s2;
		ar_s3  <= ar_s2;
		ai_s3  <= ai_s2;
		xr_s3  <= (act_s2 == ACT_MUL) ? e0 - e1 : e0 + e1;
		xi_s3  <= (act_s2 == ACT_MUL) ? e2 + e3 : e3 - e2;
		den_s3 <= DW'($unsigned(p4_s2)) + DW'($unsigned(p5_s2));
	end

	// Stage 4: direct results and divider and square root setup.
	it_t            prep;
	it_t            prep_s4;
	logic [DW-1:0]  mr, mi;
	logic [W-1:0]   arm, aim;
	logic [MW-1:0]  n_re, n_im, two_re, two_im, r0_re, r0_im;
	pk_t            pa, pb;

	always_comb begin
		mr  = xr_s3[DW-1] ? DW'(-xr_s3) : DW'(xr_s3);
		mi  = xi_s3[DW-1] ? DW'(-xi_s3) : DW'(xi_s3);
		arm = ar_s3[W-1] ? W'(-ar_s3) : W'(ar_s3);
		aim = ai_s3[W-1] ? W'(-ai_s3) : W'(ai_s3);

		pa.sat = 1'b0;
		pa.val = '0;
		pb.sat = 1'b0;
		pb.val = '0;
		case (act_s3)
			ACT_MUL: begin
				pa = sat_pack(xr_s3[DW-1], rnd_shift(MW'(mr)));
				pb = sat_pack(xi_s3[DW-1], rnd_shift(MW'(mi)));
			end
			ACT_CONJ: begin
				pa = sat_pack(ar_s3[W-1], MW'(arm));
				pb = sat_pack(ai_s3 > 0, MW'(aim));
			end
			ACT_ABS2: begin
				pa = sat_pack(1'b0, rnd_shift(MW'(den_s3)));
			end
			ACT_L1: begin
				pa = sat_pack(1'b0, MW'(arm) + MW'(aim));
			end
			default: begin
			end
		endcase

		if (act_s3 == ACT_DIV) begin
			n_re        = MW'(mr) << F;
			n_im        = MW'(mi) << F;
			prep.neg_re = xr_s3[DW-1];
			prep.neg_im = xi_s3[DW-1];
		end else begin
			n_re        = MW'(arm) << (2 * F);
			n_im        = MW'(aim) << (2 * F);
			prep.neg_re = ar_s3[W-1];
			prep.neg_im = ai_s3 > 0;
		end
		two_re = n_re << 1;
		two_im = n_im << 1;
		r0_re  = two_re >> QN;
		r0_im  = two_im >> QN;

		prep.vld    = v_s3;
		prep.act    = act_s3;
		prep.e_re   = pa.val;
		prep.e_im   = pb.val;
		prep.e_st   = (pa.sat || pb.sat) ? ST_SAT : ST_OK;
		prep.ov_re  = r0_re >= MW'(den_s3);
		prep.ov_im  = r0_im >= MW'(den_s3);
		prep.dz     = den_s3 == '0;
		prep.den    = den_s3;
		prep.r_re   = r0_re[DW-1:0];
		prep.r_im   = r0_im[DW-1:0];
		prep.low_re = two_re[QN-1:0];
		prep.low_im = two_im[QN-1:0];
		prep.q_re   = '0;
		prep.q_im   = '0;
		prep.sx     = (2 * QN)'(den_s3);
		prep.rem    = '0;
		prep.root   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s4.vld <= 1'b0;
		end else begin
			prep_s4 <= prep;
		end
	end

	// Stages 5 onward: one quotient bit per lane and one root bit per stage.
	it_t iter_s5 [QN];

	for (genvar k = 0; k < QN; k++) begin : g_iter
		it_t             src;
		it_t             nxt;
		logic [DW:0]     dr, di;
		logic [RW+1:0]   rm2, trial;

		if (k == 0) begin : g_first
			assign src = prep_s4;
		end else begin : g_next
			assign src = iter_s5[k-1];
		end

		always_comb begin
			nxt = src;
			dr  = {src.r_re, src.low_re[QN-1]};
			di  = {src.r_im, src.low_im[QN-1]};
			if (dr >= {1'b0, src.den}) begin
				dr = dr - {1'b0, src.den};
				nxt.q_re = {src.q_re[QN-2:0], 1'b1};
			end else begin
				nxt.q_re = {src.q_re[QN-2:0], 1'b0};
			end
			if (di >= {1'b0, src.den}) begin
				di = di - {1'b0, src.den};
				nxt.q_im = {src.q_im[QN-2:0], 1'b1};
			end else begin
				nxt.q_im = {src.q_im[QN-2:0], 1'b0};
			end
			nxt.r_re   = dr[DW-1:0];
			nxt.r_im   = di[DW-1:0];
			nxt.low_re = src.low_re << 1;
			nxt.low_im = src.low_im << 1;

			rm2    = {src.rem, src.sx[2*QN-1:2*QN-2]};
			trial  = (RW + 2)'({src.root, 2'b01});
			nxt.sx = src.sx << 2;
			if (rm2 >= trial) begin
				rm2      = rm2 - trial;
				nxt.root = {src.root[QN-2:0], 1'b1};
			end else begin
				nxt.root = {src.root[QN-2:0], 1'b0};
			end
			nxt.rem = rm2[RW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iter_s5[k].vld <= 1'b0;
			end else begin
				iter_s5[k] <= nxt;
			end
		end
	end

	// Output stage: rounding and saturation of the quotient and root.
	it_t           last;
	cau_res_t      res_d;
	pk_t           qa, qb, sr;
	logic [MW-1:0] root_rnd;
	logic          done_q;
	cau_res_t      result_q;

	assign last = iter_s5[QN-1];

	always_comb begin
		qa = sat_pack(last.neg_re, last.ov_re ? (MW'(1) << W)
			: ((MW'(last.q_re) + MW'(1)) >> 1));
		qb = sat_pack(last.neg_im, last.ov_im ? (MW'(1) << W)
			: ((MW'(last.q_im) + MW'(1)) >> 1));
		root_rnd = MW'(last.root) + ((MW'(last.rem) > MW'(last.root)) ? MW'(1) : MW'(0));
		sr = sat_pack(1'b0, root_rnd);

		res_d.res_re = last.e_re;
		res_d.res_im = last.e_im;
		res_d.status = last.e_st;
		case (last.act)
			ACT_DIV, ACT_INV: begin
				if (last.dz) begin
					res_d.res_re = '0;
					res_d.res_im = '0;
					res_d.status = ST_DIV0;
				end else begin
					res_d.res_re = qa.val;
					res_d.res_im = qb.val;
					res_d.status = (qa.sat || qb.sat) ? ST_SAT : ST_OK;
				end
			end
			ACT_ABS: begin
				res_d.res_re = sr.val;
				res_d.res_im = '0;
				res_d.status = sr.sat ? ST_SAT : ST_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	// Every accepted transaction completes after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted transaction did not complete on time");

	// A done without a matching accepted transaction means a spurious result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching command");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DIV0) |-> (result.res_re == '0 && result.res_im == '0))
		else $error("divide by zero result is not zero");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_SAT
			|| result.status == ST_DIV0))
		else $error("undefined status code");

endmodule
